### sv/stlk_pkg.sv
// Shared types, codes and constants of the session table with login lockout.
`default_nettype none

package stlk_pkg;

   // Slot count of the session table and its supported range.
   localparam int SESSION_SLOTS_DEFAULT = 2;
   localparam int SESSION_SLOTS_MAX     = 8;

   // Password length window, failure limit and register reset values.
   localparam logic [6:0]  MIN_PASSWORD        = 7'd10;
   localparam logic [6:0]  MAX_PASSWORD        = 7'd64;
   localparam logic [2:0]  FAIL_LIMIT          = 3'd5;
   localparam logic [31:0] LOCK_DURATION_RESET = 32'd60000;
   localparam logic [31:0] IDLE_LIMIT_RESET    = 32'd900000;

   // Command kinds carried by an input item.
   localparam logic [2:0] KIND_LOGIN    = 3'd0;
   localparam logic [2:0] KIND_VALIDATE = 3'd1;
   localparam logic [2:0] KIND_WRITE    = 3'd2;
   localparam logic [2:0] KIND_LOGOUT   = 3'd3;
   localparam logic [2:0] KIND_CLEAR    = 3'd4;

   // Configuration register port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADMIN_PRESENT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_DURATION = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IDLE_LIMIT    = 2'd2;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_REQUIRED = 3'd1,
      ST_INVALID  = 3'd2,
      ST_RATE     = 3'd3,
      ST_FAILED   = 3'd4,
      ST_EXPIRED  = 3'd5
   } status_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] now_ms;
      logic [6:0]  password_length;
      logic        password_matches;
      logic [63:0] token_high;
      logic [63:0] token_low;
      logic        token_well_formed;
      logic [2:0]  slot_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  matched_slot;
      logic [63:0] issued_token_high;
      logic [63:0] issued_token_low;
   } rsp_payload_type;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic       capture;
      logic       login_upd;
      logic       wipe;
      logic       scan_clear;
      logic       scan_step;
      logic       best_upd;
      logic       tgt_free;
      logic       tgt_best;
      logic       tgt_ptr;
      logic       tgt_slot;
      logic       deactivate;
      logic       commit;
      logic       rk_start;
      logic       rk_load;
      logic       rk_cmp;
      logic       rk_skip;
      logic       rk_fin;
      logic       res_set;
      status_type res_status;
      logic       res_full;
      logic       out_load;
   } dp_cmd_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic [2:0] kind;
      logic       login_ok;
      status_type login_status;
      logic       well;
      logic       write_ok;
      logic       free_any;
      logic       ptr_last;
      logic       hit;
      logic       idle_expired;
      logic       wrap;
      logic       outer_active;
      logic       outer_last;
   } dp_stat_type;

endpackage

`default_nettype wire

### sv/stlk_datapath.sv
// Datapath: session entries, lockout state, configuration, slot scan and result registers.
`default_nettype none

module stlk_datapath #(
   parameter int SESSION_SLOTS = stlk_pkg::SESSION_SLOTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stlk_pkg::req_payload_type           req_payload,
   input  logic                                csr_write_enable,
   input  logic [stlk_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [stlk_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  stlk_pkg::dp_cmd_type                cmd,
   output stlk_pkg::dp_stat_type               stat,
   output stlk_pkg::rsp_payload_type           rsp_payload
);
   import stlk_pkg::*;

   localparam int IDX_W = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int CNT_W = $clog2(SESSION_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSION_SLOTS - 1);

   // Configuration registers.
   logic        admin_ff;
   logic [31:0] lock_dur_ff;
   logic [31:0] idle_limit_ff;

   // Captured item.
   req_payload_type req_ff;

   // Session entries.
   logic [SESSION_SLOTS-1:0] entry_active_ff;
   logic [63:0]              entry_token_upper_ff [SESSION_SLOTS];
   logic [63:0]              entry_token_lower_ff [SESSION_SLOTS];
   logic [31:0]              entry_last_write_ff  [SESSION_SLOTS];
   logic [31:0]              entry_recency_ff     [SESSION_SLOTS];

   // Recency serial and lockout state.
   logic [31:0] recency_counter_ff;
   logic [2:0]  failure_count_ff;
   logic        locked_ff;
   logic [31:0] locked_since_ff;

   // Scan pointers and working registers.
   logic [IDX_W-1:0] ptr_ff;
   logic [IDX_W-1:0] outer_ff;
   logic [IDX_W-1:0] tgt_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic [31:0]      best_val_ff;
   logic [31:0]      cur_ff;
   logic [CNT_W-1:0] acc_ff;
   logic [CNT_W-1:0] rank_ff [SESSION_SLOTS];

   // Pending result and output register.
   status_type      res_status_ff;
   logic [2:0]      res_slot_ff;
   logic [63:0]     res_thi_ff;
   logic [63:0]     res_tlo_ff;
   rsp_payload_type rsp_payload_ff;

   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      rec_rd;
   logic             tok_hit;
   logic             free_any;
   logic [IDX_W-1:0] free_idx;
   logic [31:0]      lock_elapsed;
   logic             lock_expired;
   logic             blocked;
   logic             len_ok;
   logic [2:0]       fail_base;
   logic [2:0]       fail_next;
   logic             lock_trip;
   logic             login_proceed;
   status_type       login_status;
   logic [31:0]      idle_elapsed;
   logic             idle_expired;
   logic             slot_in_range;
   logic             write_ok;
   logic             best_take;
   logic [IDX_W-1:0] best_idx_next;
   logic             rk_less;
   logic [CNT_W-1:0] acc_next;
   logic [31:0]      serial_next;
   logic             is_login;
   logic             is_validate;
   logic             is_write;
   logic             ptr_last;
   logic             outer_last;

   assign rd_idx = cmd.rk_load ? outer_ff : ptr_ff;
   assign rec_rd = entry_recency_ff[rd_idx];

   assign ptr_last   = (ptr_ff == LAST_IDX);
   assign outer_last = (outer_ff == LAST_IDX);

   assign is_login    = (req_ff.kind == KIND_LOGIN);
   assign is_validate = (req_ff.kind == KIND_VALIDATE);
   assign is_write    = (req_ff.kind == KIND_WRITE);

   assign tok_hit = entry_active_ff[ptr_ff]
                    && (entry_token_upper_ff[ptr_ff] == req_ff.token_high)
                    && (entry_token_lower_ff[ptr_ff] == req_ff.token_low);

   // Lowest inactive slot.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
         if (!entry_active_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // Login checks and lockout bookkeeping.
   assign lock_elapsed  = req_ff.now_ms - locked_since_ff;
   assign lock_expired  = locked_ff && (lock_elapsed >= lock_dur_ff);
   assign blocked       = locked_ff && !lock_expired;
   assign len_ok        = (req_ff.password_length >= MIN_PASSWORD)
                          && (req_ff.password_length <= MAX_PASSWORD);
   assign fail_base     = lock_expired ? 3'd0 : failure_count_ff;
   assign fail_next     = fail_base + 3'd1;
   assign lock_trip     = (fail_next >= FAIL_LIMIT);
   assign login_proceed = admin_ff && len_ok && !blocked;

   always_comb begin
      if (!admin_ff) begin
         login_status = ST_REQUIRED;
      end else if (!len_ok) begin
         login_status = ST_INVALID;
      end else if (blocked) begin
         login_status = ST_RATE;
      end else if (!req_ff.password_matches) begin
         login_status = lock_trip ? ST_RATE : ST_FAILED;
      end else begin
         login_status = ST_OK;
      end
   end

   assign idle_elapsed = req_ff.now_ms - entry_last_write_ff[tgt_ff];
   assign idle_expired = (idle_elapsed >= idle_limit_ff);

   assign slot_in_range = ({1'b0, req_ff.slot_index} < 4'(SESSION_SLOTS));
   assign write_ok      = slot_in_range && entry_active_ff[req_ff.slot_index[IDX_W-1:0]];

   // Least recently used search, ties to the lower slot.
   assign best_take     = (ptr_ff == '0) || (rec_rd < best_val_ff);
   assign best_idx_next = best_take ? ptr_ff : best_idx_ff;

   // Rank of the entry under the outer pointer among the active entries.
   assign rk_less  = entry_active_ff[ptr_ff]
                     && ((rec_rd < cur_ff) || ((rec_rd == cur_ff) && (ptr_ff < outer_ff)));
   assign acc_next = acc_ff + CNT_W'(rk_less);

   assign serial_next = recency_counter_ff + 32'd1;

   always_comb begin
      stat              = '0;
      stat.kind         = req_ff.kind;
      stat.login_ok     = (login_status == ST_OK);
      stat.login_status = login_status;
      stat.well         = req_ff.token_well_formed;
      stat.write_ok     = write_ok;
      stat.free_any     = free_any;
      stat.ptr_last     = ptr_last;
      stat.hit          = tok_hit;
      stat.idle_expired = idle_expired;
      stat.wrap         = (recency_counter_ff == '1);
      stat.outer_active = entry_active_ff[outer_ff];
      stat.outer_last   = outer_last;
   end

   // Control state: configuration, lockout, serial counter and active bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         admin_ff           <= 1'b0;
         lock_dur_ff        <= LOCK_DURATION_RESET;
         idle_limit_ff      <= IDLE_LIMIT_RESET;
         failure_count_ff   <= '0;
         locked_ff          <= 1'b0;
         locked_since_ff    <= '0;
         recency_counter_ff <= '0;
         entry_active_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ADMIN_PRESENT: admin_ff      <= csr_write_data[0];
               CSR_LOCK_DURATION: lock_dur_ff   <= csr_write_data;
               CSR_IDLE_LIMIT:    idle_limit_ff <= csr_write_data;
               default: ;
            endcase
         end
         if (cmd.login_upd && login_proceed) begin
            if (lock_expired) begin
               locked_ff <= 1'b0;
            end
            if (req_ff.password_matches) begin
               failure_count_ff <= '0;
            end else begin
               failure_count_ff <= fail_next;
               if (lock_trip) begin
                  locked_ff       <= 1'b1;
                  locked_since_ff <= req_ff.now_ms;
               end
            end
         end
         if (cmd.commit) begin
            recency_counter_ff <= serial_next;
         end else if (cmd.rk_fin) begin
            recency_counter_ff <= 32'($countones(entry_active_ff));
         end
         if (cmd.wipe) begin
            entry_active_ff <= '0;
         end else if (cmd.deactivate) begin
            entry_active_ff[tgt_ff] <= 1'b0;
         end else if (cmd.commit && is_login) begin
            entry_active_ff[tgt_ff] <= 1'b1;
         end
      end
   end

   // Entry payloads.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         entry_recency_ff[tgt_ff] <= serial_next;
         if (is_login) begin
            entry_token_upper_ff[tgt_ff] <= req_ff.token_high;
            entry_token_lower_ff[tgt_ff] <= req_ff.token_low;
            entry_last_write_ff[tgt_ff]  <= req_ff.now_ms;
         end else if (is_write) begin
            entry_last_write_ff[tgt_ff]  <= req_ff.now_ms;
         end
      end else if (cmd.rk_fin) begin
         for (int i = 0; i < SESSION_SLOTS; i++) begin
            if (entry_active_ff[i]) begin
               entry_recency_ff[i] <= 32'(rank_ff[i]);
            end
         end
      end
   end

   // Scan pointers, search and ranking registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end

      if (cmd.scan_clear || cmd.rk_load) begin
         ptr_ff <= '0;
      end else if ((cmd.scan_step || cmd.rk_cmp) && !ptr_last) begin
         ptr_ff <= ptr_ff + 1'b1;
      end

      if (cmd.rk_start) begin
         outer_ff <= '0;
      end else if ((cmd.rk_skip || (cmd.rk_cmp && ptr_last)) && !outer_last) begin
         outer_ff <= outer_ff + 1'b1;
      end

      if (cmd.rk_load) begin
         cur_ff <= rec_rd;
         acc_ff <= CNT_W'(1);
      end else if (cmd.rk_cmp) begin
         acc_ff <= acc_next;
         if (ptr_last) begin
            rank_ff[outer_ff] <= acc_next;
         end
      end

      if (cmd.best_upd && best_take) begin
         best_val_ff <= rec_rd;
         best_idx_ff <= ptr_ff;
      end

      if (cmd.tgt_free) begin
         tgt_ff <= free_idx;
      end else if (cmd.tgt_best) begin
         tgt_ff <= best_idx_next;
      end else if (cmd.tgt_ptr) begin
         tgt_ff <= ptr_ff;
      end else if (cmd.tgt_slot) begin
         tgt_ff <= req_ff.slot_index[IDX_W-1:0];
      end
   end

   // Pending result and output register.
   always_ff @(posedge clock) begin
      if (cmd.res_set) begin
         res_status_ff <= cmd.res_status;
         if (cmd.res_full && (is_login || is_validate)) begin
            res_slot_ff <= 3'(tgt_ff);
         end else begin
            res_slot_ff <= 3'd0;
         end
         if (cmd.res_full && is_login) begin
            res_thi_ff <= req_ff.token_high;
            res_tlo_ff <= req_ff.token_low;
         end else begin
            res_thi_ff <= '0;
            res_tlo_ff <= '0;
         end
      end
      if (cmd.out_load) begin
         rsp_payload_ff.status            <= 3'(res_status_ff);
         rsp_payload_ff.matched_slot      <= res_slot_ff;
         rsp_payload_ff.issued_token_high <= res_thi_ff;
         rsp_payload_ff.issued_token_low  <= res_tlo_ff;
      end
   end

   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### sv/stlk_ctrl.sv
// Sequencer: steps one command item through decode, slot scans, re-ranking and result hand-off.
`default_nettype none

module stlk_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  stlk_pkg::dp_stat_type  stat,
   output stlk_pkg::dp_cmd_type   cmd
);
   import stlk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LRU,
      S_FIND,
      S_FOUND,
      S_COMMIT,
      S_RK_LOAD,
      S_RK_CMP,
      S_RK_FIN,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (stat.kind)
               KIND_LOGIN: begin
                  cmd.login_upd = 1'b1;
                  if (stat.login_ok) begin
                     if (stat.free_any) begin
                        cmd.tgt_free = 1'b1;
                        state_in     = S_COMMIT;
                     end else begin
                        cmd.scan_clear = 1'b1;
                        state_in       = S_LRU;
                     end
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = stat.login_status;
                     state_in       = S_DONE;
                  end
               end
               KIND_VALIDATE, KIND_LOGOUT: begin
                  if (stat.well) begin
                     cmd.scan_clear = 1'b1;
                     state_in       = S_FIND;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_REQUIRED;
                     state_in       = S_DONE;
                  end
               end
               KIND_WRITE: begin
                  if (stat.write_ok) begin
                     cmd.tgt_slot = 1'b1;
                     state_in     = S_COMMIT;
                  end else begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = ST_OK;
                     state_in       = S_DONE;
                  end
               end
               KIND_CLEAR: begin
                  cmd.wipe       = 1'b1;
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_OK;
                  state_in       = S_DONE;
               end
               default: begin
                  cmd.res_set    = 1'b1;
                  cmd.res_status = ST_REQUIRED;
                  state_in       = S_DONE;
               end
            endcase
         end
         S_LRU: begin
            cmd.best_upd = 1'b1;
            if (stat.ptr_last) begin
               cmd.tgt_best = 1'b1;
               state_in     = S_COMMIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FIND: begin
            if (stat.hit) begin
               cmd.tgt_ptr = 1'b1;
               state_in    = S_FOUND;
            end else if (stat.ptr_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_REQUIRED;
               state_in       = S_DONE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FOUND: begin
            if (stat.kind == KIND_LOGOUT) begin
               cmd.deactivate = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_DONE;
            end else if (stat.idle_expired) begin
               cmd.deactivate = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_EXPIRED;
               state_in       = S_DONE;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (stat.wrap) begin
               cmd.rk_start = 1'b1;
               state_in     = S_RK_LOAD;
            end else begin
               cmd.commit     = 1'b1;
               cmd.res_set    = 1'b1;
               cmd.res_status = ST_OK;
               cmd.res_full   = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_RK_LOAD: begin
            if (stat.outer_active) begin
               cmd.rk_load = 1'b1;
               state_in    = S_RK_CMP;
            end else if (stat.outer_last) begin
               state_in = S_RK_FIN;
            end else begin
               cmd.rk_skip = 1'b1;
            end
         end
         S_RK_CMP: begin
            cmd.rk_cmp = 1'b1;
            if (stat.ptr_last) begin
               state_in = stat.outer_last ? S_RK_FIN : S_RK_LOAD;
            end
         end
         S_RK_FIN: begin
            cmd.rk_fin = 1'b1;
            state_in   = S_COMMIT;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### sv/session_table_with_login_lockout.sv
// Top level of the login session table with failed-login lockout.
`default_nettype none

// The block keeps SESSION_SLOTS login sessions, each with a 128-bit token, the time of
// its last write and a recency serial, plus a failed-login counter that locks login for
// lock_duration_ms after five failures in a row. Each request item carries one command
// (login, validate, record write, logout or clear) and yields exactly one result item.
// Items are handled one at a time by a sequencer that walks a slot pointer over the
// table, with an outer pointer too while re-ranking, so the work for an item depends
// on the command and the slot count N. Clear, unknown commands, rejected logins,
// record writes to an inactive or out-of-range slot, and validate or logout with a
// malformed token are answered from the decode step. A login into a free slot and a
// record write to a live slot go from decode straight to the commit step. A login
// that must evict the least recently used slot first scans all N slots. Validate and
// logout scan the slots up to and including the match, or all N when the token is not
// found; a logout or an expired session is then answered, and a refreshed session goes
// on to the commit step. When the 32-bit recency serial is exhausted, the active
// entries are re-ranked, each against every slot, before the serial is taken. A new
// item is accepted as soon as the previous result has moved into the output register,
// even if the consumer has not yet taken it. Configuration registers (0: admin_present,
// 1: lock_duration_ms, 2: idle_limit_ms) are written through the csr port and must only
// change while the block is idle. Reset is synchronous and needs no clearing pass: all
// sessions start inactive.

module session_table_with_login_lockout #(
   parameter int SESSION_SLOTS = stlk_pkg::SESSION_SLOTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_ready,
   input  stlk_pkg::req_payload_type          req_payload,

   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output stlk_pkg::rsp_payload_type          rsp_payload,

   input  logic                               csr_write_enable,
   input  logic [stlk_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stlk_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import stlk_pkg::*;

   // Command and status groups between the sequencer and the datapath.
   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   // The sequencer owns the handshake and the state of the current item.
   stlk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   // The datapath holds the session entries, lockout state, configuration registers
   // and the output register that carries the result item.
   stlk_datapath #(
      .SESSION_SLOTS (SESSION_SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cmd              (dp_cmd),
      .stat             (dp_stat),
      .rsp_payload      (rsp_payload)
   );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the login session table with failed-login lockout.
`timescale 1ns / 1ps

module tb_top;
   import stlk_pkg::*;

   // Slot count of the instance; the session model below is sized to match.
   localparam int SLOTS = SESSION_SLOTS_DEFAULT;

   // The first command code past the defined ones. Codes from here up to the top
   // of the field are unknown commands and must answer required.
   localparam logic [2:0] KIND_UNKNOWN_LOW = KIND_CLEAR + 3'd1;

   // Random traffic is split into phases, each with its own register setting.
   localparam int PHASES           = 8;
   localparam int RANDOM_PER_PHASE = 112;
   localparam int BACKPRESSURE_ITEMS = 30;

   // Length of the receiver's hold-off when the pressure test asks for one.
   localparam int LONG_HOLD = 400;

   // Idle cycles let pass after the last result before a register write or the end.
   localparam int SETTLE_CYCLES = 24;

   // Watchdog. The limit allows every item its longest scan, the longest sender gap
   // and receiver stall, the long hold-off and the settle pauses, several times over.
   localparam int CYCLE_LIMIT = 600000;

   // Receiver stall styles. Each style lasts a random stretch of cycles.
   typedef enum int {
      SINK_OPEN,
      SINK_COIN,
      SINK_PATTERN,
      SINK_SPARSE
   } sink_style_type;

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;
   logic            csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   session_table_with_login_lockout #(
      .SESSION_SLOTS(SLOTS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Session model. This is the testbench's own copy of the block's state and
   // registers. It is advanced once per accepted item, in acceptance order, and
   // each step yields the one result item that the block must return.
   // ------------------------------------------------------------------------
   bit          cfg_admin;
   bit [31:0]   cfg_lock_ms;
   bit [31:0]   cfg_idle_ms;

   bit          sess_live    [SLOTS];
   bit [63:0]   sess_tok_hi  [SLOTS];
   bit [63:0]   sess_tok_lo  [SLOTS];
   bit [31:0]   sess_written [SLOTS];
   bit [31:0]   sess_rank    [SLOTS];
   bit [31:0]   rank_counter;
   bit [2:0]    fail_streak;
   bit          lock_on;
   bit [31:0]   lock_start;

   // Results still owed by the block, oldest first.
   rsp_payload_type pending_outcomes [$];

   // Bookkeeping shared by the stimulus, the checker and the summary.
   int  mismatch_count   = 0;
   int  items_sent       = 0;
   int  results_checked  = 0;
   int  settings_applied = 0;
   int  status_tally [8];
   int  cycle_count      = 0;

   // Sender and receiver pacing controls.
   bit        gaps_on          = 1'b0;
   int        burst_left       = 0;
   bit        hold_off_request = 1'b0;

   // Millisecond time carried by generated items. It wraps modulo 2^32 like the
   // block's own arithmetic.
   bit [31:0] wall_ms = '0;

   function automatic void reset_session_model();
      cfg_admin   = 1'b0;
      cfg_lock_ms = LOCK_DURATION_RESET;
      cfg_idle_ms = IDLE_LIMIT_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         sess_live[i]    = 1'b0;
         sess_tok_hi[i]  = '0;
         sess_tok_lo[i]  = '0;
         sess_written[i] = '0;
         sess_rank[i]    = '0;
      end
      rank_counter = '0;
      fail_streak  = '0;
      lock_on      = 1'b0;
      lock_start   = '0;
   endfunction

   // Hands out the next recency serial. When the serial counter is exhausted the
   // live sessions are re-ranked 1..n in their old order, ties going to the lower
   // slot, and counting resumes from n.
   function automatic bit [31:0] next_rank();
      int order [SLOTS];
      int live_count;
      int cur;
      int j;
      live_count = 0;
      if (rank_counter == 32'hFFFF_FFFF) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (sess_live[i]) begin
               order[live_count] = i;
               live_count++;
            end
         end
         for (int i = 1; i < live_count; i++) begin
            cur = order[i];
            j = i;
            while (j > 0 && sess_rank[cur] < sess_rank[order[j - 1]]) begin
               order[j] = order[j - 1];
               j--;
            end
            order[j] = cur;
         end
         for (int i = 0; i < live_count; i++) begin
            sess_rank[order[i]] = 32'(i + 1);
         end
         rank_counter = 32'(live_count);
      end
      rank_counter = rank_counter + 32'd1;
      return rank_counter;
   endfunction

   // Lowest live slot holding the token, or -1.
   function automatic int find_session(bit [63:0] hi, bit [63:0] lo);
      for (int i = 0; i < SLOTS; i++) begin
         if (sess_live[i] && sess_tok_hi[i] == hi && sess_tok_lo[i] == lo) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one command to the model and returns the result item it causes.
   function automatic rsp_payload_type session_outcome(req_payload_type cmd);
      rsp_payload_type res;
      bit [31:0]       elapsed;
      bit              blocked;
      int              slot;
      res        = '0;
      res.status = ST_REQUIRED;
      case (cmd.kind)
         KIND_LOGIN: begin
            if (!cfg_admin) begin
               res.status = ST_REQUIRED;
            end else if (cmd.password_length < MIN_PASSWORD ||
                         cmd.password_length > MAX_PASSWORD) begin
               res.status = ST_INVALID;
            end else begin
               // A lock whose window has run out is dropped, together with the
               // failure streak, before the password is looked at.
               blocked = 1'b0;
               if (lock_on) begin
                  elapsed = cmd.now_ms - lock_start;
                  if (elapsed < cfg_lock_ms) begin
                     blocked = 1'b1;
                  end else begin
                     lock_on     = 1'b0;
                     fail_streak = '0;
                  end
               end
               if (blocked) begin
                  res.status = ST_RATE;
               end else if (!cmd.password_matches) begin
                  fail_streak = fail_streak + 3'd1;
                  if (fail_streak >= FAIL_LIMIT) begin
                     lock_on    = 1'b1;
                     lock_start = cmd.now_ms;
                     res.status = ST_RATE;
                  end else begin
                     res.status = ST_FAILED;
                  end
               end else begin
                  // First free slot, otherwise the least recently used one.
                  fail_streak = '0;
                  slot = -1;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (!sess_live[i] && slot < 0) slot = i;
                  end
                  if (slot < 0) begin
                     slot = 0;
                     for (int i = 1; i < SLOTS; i++) begin
                        if (sess_rank[i] < sess_rank[slot]) slot = i;
                     end
                  end
                  sess_tok_hi[slot]  = cmd.token_high;
                  sess_tok_lo[slot]  = cmd.token_low;
                  sess_written[slot] = cmd.now_ms;
                  sess_rank[slot]    = next_rank();
                  sess_live[slot]    = 1'b1;
                  res.status            = ST_OK;
                  res.matched_slot      = 3'(slot);
                  res.issued_token_high = cmd.token_high;
                  res.issued_token_low  = cmd.token_low;
               end
            end
         end
         KIND_VALIDATE: begin
            slot = cmd.token_well_formed ? find_session(cmd.token_high, cmd.token_low) : -1;
            if (slot >= 0) begin
               elapsed = cmd.now_ms - sess_written[slot];
               if (elapsed >= cfg_idle_ms) begin
                  sess_live[slot] = 1'b0;
                  res.status = ST_EXPIRED;
               end else begin
                  sess_rank[slot]  = next_rank();
                  res.status       = ST_OK;
                  res.matched_slot = 3'(slot);
               end
            end
         end
         KIND_WRITE: begin
            if (cmd.slot_index < SLOTS && sess_live[cmd.slot_index]) begin
               sess_written[cmd.slot_index] = cmd.now_ms;
               sess_rank[cmd.slot_index]    = next_rank();
            end
            res.status = ST_OK;
         end
         KIND_LOGOUT: begin
            slot = cmd.token_well_formed ? find_session(cmd.token_high, cmd.token_low) : -1;
            if (slot >= 0) begin
               sess_live[slot] = 1'b0;
               res.status = ST_OK;
            end
         end
         KIND_CLEAR: begin
            // The serial counter survives a clear.
            for (int i = 0; i < SLOTS; i++) begin
               sess_live[i]    = 1'b0;
               sess_tok_hi[i]  = '0;
               sess_tok_lo[i]  = '0;
               sess_written[i] = '0;
               sess_rank[i]    = '0;
            end
            res.status = ST_OK;
         end
         default: begin
            res.status = ST_REQUIRED;
         end
      endcase
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------------
   function automatic req_payload_type make_cmd(logic [2:0] kind, logic [31:0] now,
                                                logic [6:0] plen, logic match,
                                                logic [63:0] hi, logic [63:0] lo,
                                                logic well, logic [2:0] slot);
      req_payload_type cmd;
      cmd.kind              = kind;
      cmd.now_ms            = now;
      cmd.password_length   = plen;
      cmd.password_matches  = match;
      cmd.token_high        = hi;
      cmd.token_low         = lo;
      cmd.token_well_formed = well;
      cmd.slot_index        = slot;
      return cmd;
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly small steps so that sessions live long enough to be used, with some
   // long steps that run past idle limits and lock windows, and rare jumps to an
   // arbitrary time so that differences across the wrap are exercised.
   function automatic void advance_wall_clock();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) wall_ms += $urandom_range(0, 40);
      else if (roll < 85) wall_ms += $urandom_range(0, 3000);
      else if (roll < 97) wall_ms += $urandom_range(0, 2000000);
      else wall_ms = $urandom;
   endfunction

   // Most random items are well-formed commands that act on live sessions: a
   // validate or logout presents a token that a slot really holds, and a record
   // write names a real slot. The rest is noise: any command code, any password
   // length up to one past the window, malformed or slightly corrupted tokens and any slot number.
   function automatic req_payload_type random_command(int miss_pct);
      req_payload_type cmd;
      int roll;
      int s;
      roll = $urandom_range(0, 99);
      s    = $urandom_range(0, SLOTS - 1);
      cmd = make_cmd(KIND_LOGIN, wall_ms,
                     7'($urandom_range(MIN_PASSWORD, MAX_PASSWORD)),
                     $urandom_range(0, 99) >= miss_pct,
                     random_word(), random_word(), 1'b1, 3'(s));
      if (roll >= 30 && roll < 84 && sess_live[s]) begin
         cmd.token_high = sess_tok_hi[s];
         cmd.token_low  = sess_tok_lo[s];
      end
      if (roll < 30) begin
         cmd.kind = KIND_LOGIN;
      end else if (roll < 55) begin
         cmd.kind = KIND_VALIDATE;
      end else if (roll < 70) begin
         cmd.kind = KIND_WRITE;
      end else if (roll < 80) begin
         cmd.kind = KIND_LOGOUT;
      end else if (roll < 84) begin
         cmd.kind = KIND_CLEAR;
      end else begin
         cmd.kind              = 3'($urandom);
         cmd.password_length   = 7'($urandom_range(0, MAX_PASSWORD + 1));
         cmd.password_matches  = 1'($urandom);
         cmd.token_well_formed = 1'($urandom);
         cmd.slot_index        = 3'($urandom);
         if (sess_live[s] && $urandom_range(0, 1) == 1) begin
            // A live token with one bit flipped must not be found.
            cmd.token_high = sess_tok_hi[s];
            cmd.token_low  = sess_tok_lo[s];
            if ($urandom_range(0, 1) == 1) cmd.token_low[$urandom_range(0, 63)] ^= 1'b1;
            else cmd.token_high[$urandom_range(0, 63)] ^= 1'b1;
         end
      end
      return cmd;
   endfunction

   // Offers one item and returns at the edge where it is accepted. With gaps on, the
   // sender runs in bursts; between bursts valid drops for a random number of cycles.
   // The expected result is worked out at acceptance, so the model sees items in
   // exactly the order the block does.
   task automatic send_command(input req_payload_type cmd);
      int gap;
      gap = 0;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 10);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= cmd;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_outcomes.push_back(session_outcome(cmd));
      items_sent++;
   endtask

   // Stops offering items, waits for every owed result and lets the block go
   // quiet. Register writes and the end of the run only happen after this.
   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all three registers on consecutive edges. The unused upper bits of
   // the admin register carry noise, which the block must ignore.
   task automatic apply_settings(input logic admin, input logic [31:0] lock_ms,
                                 input logic [31:0] idle_ms);
      drain_and_idle();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ADMIN_PRESENT;
      csr_write_data   <= {31'($urandom), admin};
      @(posedge clock);
      cfg_admin = admin;
      csr_index      <= CSR_LOCK_DURATION;
      csr_write_data <= lock_ms;
      @(posedge clock);
      cfg_lock_ms = lock_ms;
      csr_index      <= CSR_IDLE_LIMIT;
      csr_write_data <= idle_ms;
      @(posedge clock);
      cfg_idle_ms = idle_ms;
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Login gating, slot allocation with eviction, every command kind, bad slots,
   // malformed tokens, unknown codes and a clear.
   task automatic test_login_rules();
      logic [63:0] third_hi;
      logic [63:0] third_lo;
      third_hi = random_word();
      third_lo = random_word();
      gaps_on  = 1'b0;

      // Straight out of reset there is no stored credential.
      send_command(make_cmd(KIND_LOGIN, '1, 7'd20, 1'b1, '1, '1, 1'b1, 3'd0));
      apply_settings(1'b1, 32'd100, 32'd1000);

      // Password lengths just outside the window, and empty.
      send_command(make_cmd(KIND_LOGIN, 32'd1, MIN_PASSWORD - 7'd1, 1'b1, '0, '0, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd2, MAX_PASSWORD + 7'd1, 1'b1, '0, '0, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd3, 7'd0, 1'b1, '0, '0, 1'b1, 3'd0));

      // Fill both slots with all-ones and all-zeros tokens at the length edges,
      // touch the first, then a third login must evict the second.
      send_command(make_cmd(KIND_LOGIN, 32'd10, MIN_PASSWORD, 1'b1, '1, '1, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd20, MAX_PASSWORD, 1'b1, '0, '0, 1'b0, '1));
      send_command(make_cmd(KIND_VALIDATE, 32'd30, 7'd0, 1'b0, '1, '1, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd40, 7'd33, 1'b1, third_hi, third_lo, 1'b1, 3'd0));

      // A malformed token is never found; an evicted token is gone.
      send_command(make_cmd(KIND_VALIDATE, 32'd41, 7'd0, 1'b0, '1, '1, 1'b0, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd42, 7'd0, 1'b0, '0, '0, 1'b1, 3'd0));

      // Record writes: a live slot, a slot past the table, and after a logout
      // an inactive slot. Logout of a token already logged out is refused.
      send_command(make_cmd(KIND_WRITE, 32'd50, 7'd0, 1'b0, '0, '0, 1'b0, 3'd0));
      send_command(make_cmd(KIND_WRITE, 32'd51, 7'd0, 1'b0, '0, '0, 1'b0, '1));
      send_command(make_cmd(KIND_LOGOUT, 32'd52, 7'd0, 1'b0, third_hi, third_lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGOUT, 32'd53, 7'd0, 1'b0, third_hi, third_lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_WRITE, 32'd54, 7'd0, 1'b0, '0, '0, 1'b0, 3'd1));

      // Unknown command codes change nothing.
      for (int k = 0; k < 3; k++) begin
         send_command(make_cmd(KIND_UNKNOWN_LOW + 3'(k), 32'd60, 7'd20, 1'b1,
                               random_word(), random_word(), 1'b1, 3'(k)));
      end

      // Clear wipes the table; the surviving token is no longer accepted.
      send_command(make_cmd(KIND_CLEAR, 32'd70, 7'd0, 1'b0, '0, '0, 1'b0, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd71, 7'd0, 1'b0, '1, '1, 1'b1, 3'd0));
   endtask

   // Five failures in a row lock login. The lock window is measured across the
   // 32-bit time wrap, a password length error still wins during a lock, a zero
   // duration never blocks and the longest duration holds a long time.
   task automatic test_lockout();
      logic [31:0] base;
      base    = 32'hFFFF_FFC0;
      gaps_on = 1'b0;

      apply_settings(1'b1, 32'd100, '1);
      repeat (5) send_command(make_cmd(KIND_LOGIN, base, 7'd16, 1'b0,
                                       random_word(), random_word(), 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, base + 32'd1, MAX_PASSWORD + 7'd1, 1'b1,
                            random_word(), random_word(), 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, base + 32'd50, 7'd16, 1'b1,
                            random_word(), random_word(), 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, base + 32'd100, 7'd16, 1'b1,
                            random_word(), random_word(), 1'b1, 3'd0));

      apply_settings(1'b1, 32'd0, '1);
      repeat (5) send_command(make_cmd(KIND_LOGIN, 32'd500, 7'd40, 1'b0,
                                       random_word(), random_word(), 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd500, 7'd40, 1'b1,
                            random_word(), random_word(), 1'b1, 3'd0));

      apply_settings(1'b1, '1, '1);
      repeat (5) send_command(make_cmd(KIND_LOGIN, 32'd900, 7'd40, 1'b0,
                                       random_word(), random_word(), 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGIN, 32'd1_000_000_900, 7'd40, 1'b1,
                            random_word(), random_word(), 1'b1, 3'd0));
   endtask

   // Idle limits of zero and one (logins still refused by the lockout test's lock), the
   // largest limit across the time wrap, and a record write that keeps a session alive.
   task automatic test_idle_expiry();
      logic [63:0] hi;
      logic [63:0] lo;
      gaps_on = 1'b0;

      apply_settings(1'b1, 32'd60000, 32'd0);
      hi = random_word();
      lo = random_word();
      send_command(make_cmd(KIND_LOGIN, 32'd1000, 7'd12, 1'b1, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd1000, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));

      apply_settings(1'b1, 32'd60000, 32'd1);
      hi = random_word();
      lo = random_word();
      send_command(make_cmd(KIND_LOGIN, 32'd5000, 7'd12, 1'b1, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd5000, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd5001, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));

      apply_settings(1'b1, 32'd60000, '1);
      hi = random_word();
      lo = random_word();
      send_command(make_cmd(KIND_LOGIN, 32'hFFFF_FFF0, 7'd12, 1'b1, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'h20, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));

      apply_settings(1'b1, 32'd60000, 32'd500);
      hi = random_word();
      lo = random_word();
      send_command(make_cmd(KIND_LOGIN, 32'd7000, 7'd12, 1'b1, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_WRITE, 32'd7400, 7'd0, 1'b0, '0, '0, 1'b0,
                            3'(find_session(hi, lo))));
      send_command(make_cmd(KIND_VALIDATE, 32'd7800, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_VALIDATE, 32'd8300, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));
      send_command(make_cmd(KIND_LOGOUT, 32'd8301, 7'd0, 1'b0, hi, lo, 1'b1, 3'd0));
   endtask

   // Random traffic in phases. Each phase has its own lock and idle setting,
   // extremes included, a high or a low failure rate and either bursty or steady
   // sending. One phase runs without a stored credential.
   task automatic test_random_traffic();
      logic [31:0] lock_choice [PHASES];
      logic [31:0] idle_choice [PHASES];
      int          miss_pct;
      lock_choice = '{32'd1, 32'd100, 32'd3000, 32'd60000, 32'hFFFF_FFFF, 32'd0,
                      32'd500, 32'd20};
      idle_choice = '{32'd200, 32'hFFFF_FFFF, 32'd1, 32'd5000, 32'd0, 32'd900000,
                      32'd50, 32'd2000};
      for (int p = 0; p < PHASES; p++) begin
         apply_settings(p != 6, lock_choice[p], idle_choice[p]);
         gaps_on  = (p % 2 == 0);
         miss_pct = (p % 3 == 1) ? 70 : 15;
         wall_ms  = $urandom;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            advance_wall_clock();
            send_command(random_command(miss_pct));
         end
      end
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering
   // items back to back, so the block fills up and must stall its input.
   task automatic test_backpressure();
      apply_settings(1'b1, 32'd300, 32'd4000);
      gaps_on          = 1'b0;
      hold_off_request = 1'b1;
      for (int n = 0; n < BACKPRESSURE_ITEMS; n++) begin
         advance_wall_clock();
         send_command(random_command(20));
      end
   endtask

   // ------------------------------------------------------------------------
   // Receiver. It changes stall style after a random stretch of cycles: always ready, a
   // coin toss per cycle, a fixed stall pattern, or rare stalls. A hold-off
   // request from a test overrides the style with a long stall.
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      sink_style_type style;
      int             style_left;
      int             hold_left;
      int             tick;
      style      = SINK_OPEN;
      style_left = 0;
      hold_left  = 0;
      tick       = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left        = LONG_HOLD;
         end
         if (style_left == 0) begin
            style      = sink_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               SINK_OPEN:    rsp_ready <= 1'b1;
               SINK_COIN:    rsp_ready <= 1'($urandom);
               SINK_PATTERN: rsp_ready <= (tick % 8) >= 3;
               default:      rsp_ready <= $urandom_range(0, 9) != 0;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checker. Every accepted result is compared field by field with the
   // oldest owed result. Values are sampled at the edge, before any update that
   // the same edge brings.
   // ------------------------------------------------------------------------
   function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("tb_top: %s expected 0x%0h, got 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("tb_top: result item with none owed, status %0d", rsp_payload.status);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            status_tally[want.status]++;
            check_field("status", want.status, rsp_payload.status);
            check_field("matched_slot", want.matched_slot, rsp_payload.matched_slot);
            check_field("issued_token_high", want.issued_token_high,
                        rsp_payload.issued_token_high);
            check_field("issued_token_low", want.issued_token_low,
                        rsp_payload.issued_token_low);
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d results owed", cycle_count,
                  pending_outcomes.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence. Every input is driven from time zero, reset is held and released
   // once, then the tests run in turn.
   // ------------------------------------------------------------------------
   initial begin
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_payload      <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      foreach (status_tally[i]) status_tally[i] = 0;
      reset_session_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_login_rules();
      test_lockout();
      test_idle_expiry();
      test_random_traffic();
      test_backpressure();
      drain_and_idle();

      $display("tb_top: %0d items sent and %0d results checked under %0d register settings",
               items_sent, results_checked, settings_applied);
      $display("tb_top: ok %0d, required %0d, invalid %0d, rate %0d, failed %0d, expired %0d",
               status_tally[ST_OK], status_tally[ST_REQUIRED], status_tally[ST_INVALID],
               status_tally[ST_RATE], status_tally[ST_FAILED], status_tally[ST_EXPIRED]);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
